@@ hdl/uvst_pkg.sv @@
// Shared types and codes for the unique value set table.
// No dependencies; used by unique_value_set_table.
package uvst_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_MISS,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

endpackage

@@ hdl/unique_value_set_table.sv @@
// Unique value set table: packed set of distinct 64-bit keys in a memory with one read and one write port.
// Depends on uvst_pkg (action codes, field widths, sequencer states).
//
// Usage: a request (action, key) is taken on the input channel when in_valid is
// high and in_stall is low. Actions: add, remove, lookup, clear. Exactly one
// result (found, position, count, full_drop) leaves on the output channel per
// request, in order, taken when out_valid is high and out_stall is low.
// One 64-bit comparator walks the stored entries one at a time; each entry
// visited takes a registered memory read, then a compare. A hit goes to the
// done step; a miss passes through the miss step first. A clear goes straight
// to the done step, a request on an empty set straight to the miss step.
// A remove then shifts every later entry down through the same memory, a read
// step and a write step per moved entry. in_stall is high while a request is in work.
// The result sits in an output register: the next request is taken while it
// waits, and a stalled result holds until taken; a finished request waits in
// its last step while the output register is still occupied.
// Reset (rst, synchronous) empties the set and drops any pending result; the
// memory itself is not cleared, since only entries below the count are read.
module unique_value_set_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [uvst_pkg::KEY_W-1:0]    key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [uvst_pkg::POS_W-1:0]    position,
  output logic [uvst_pkg::COUNT_W-1:0]  count,
  output logic                          full_drop
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  uvst_pkg::state_t state, state_next;

  logic [1:0]                 act, act_next;
  logic [uvst_pkg::KEY_W-1:0] key_r, key_next;
  logic [IW-1:0]              idx, idx_next;
  logic [IW-1:0]              pos, pos_next;
  logic                       hit, hit_next;
  logic                       drop, drop_next;
  logic [CW-1:0]              entry_count, entry_count_next;
  logic                       out_valid_next;
  logic                       out_load;

  logic [uvst_pkg::KEY_W-1:0] mem [CAPACITY];
  logic [uvst_pkg::KEY_W-1:0] rdata;
  logic                       mem_we;
  logic [IW-1:0]              waddr;
  logic [IW-1:0]              raddr;
  logic [uvst_pkg::KEY_W-1:0] wdata;

  logic [CW:0] idx_p1;
  logic [CW:0] idx_p2;
  logic [CW:0] cnt_ext;

  assign idx_p1  = (CW+1)'(idx) + (CW+1)'(1);
  assign idx_p2  = (CW+1)'(idx) + (CW+1)'(2);
  assign cnt_ext = {1'b0, entry_count};

  assign in_stall = (state != uvst_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= uvst_pkg::S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act   <= act_next;
    key_r <= key_next;
    idx   <= idx_next;
    pos   <= pos_next;
    hit   <= hit_next;
    drop  <= drop_next;
    if (out_load) begin
      found     <= hit;
      position  <= uvst_pkg::POS_W'(pos);
      count     <= uvst_pkg::COUNT_W'(entry_count);
      full_drop <= drop;
    end
  end

  always_comb begin
    state_next       = state;
    act_next         = act;
    key_next         = key_r;
    idx_next         = idx;
    pos_next         = pos;
    hit_next         = hit;
    drop_next        = drop;
    entry_count_next = entry_count;
    mem_we           = 1'b0;
    waddr            = idx;
    wdata            = key_r;
    raddr            = idx;
    out_load         = 1'b0;
    out_valid_next   = out_valid && out_stall;

    case (state)
      uvst_pkg::S_IDLE: begin
        if (in_valid) begin
          act_next  = action;
          key_next  = key;
          idx_next  = '0;
          pos_next  = '0;
          hit_next  = 1'b0;
          drop_next = 1'b0;
          if (action == uvst_pkg::ACT_CLEAR) begin
            entry_count_next = '0;
            state_next       = uvst_pkg::S_DONE;
          end else if (entry_count == '0) begin
            state_next = uvst_pkg::S_MISS;
          end else begin
            state_next = uvst_pkg::S_RD;
          end
        end
      end

      uvst_pkg::S_RD: begin
        raddr      = idx;
        state_next = uvst_pkg::S_CMP;
      end

      uvst_pkg::S_CMP: begin
        if (rdata == key_r) begin
          hit_next = 1'b1;
          pos_next = idx;
          if (act == uvst_pkg::ACT_REMOVE) begin
            if (idx_p1 < cnt_ext) begin
              state_next = uvst_pkg::S_SH_RD;
            end else begin
              entry_count_next = entry_count - CW'(1);
              state_next       = uvst_pkg::S_DONE;
            end
          end else begin
            state_next = uvst_pkg::S_DONE;
          end
        end else if (idx_p1 == cnt_ext) begin
          state_next = uvst_pkg::S_MISS;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = uvst_pkg::S_RD;
        end
      end

      uvst_pkg::S_MISS: begin
        // only an add changes the set on a miss
        if (act == uvst_pkg::ACT_ADD) begin
          if (cnt_ext < (CW+1)'(CAPACITY)) begin
            mem_we           = 1'b1;
            waddr            = IW'(entry_count);
            wdata            = key_r;
            entry_count_next = entry_count + CW'(1);
          end else begin
            drop_next = 1'b1;
          end
        end
        state_next = uvst_pkg::S_DONE;
      end

      uvst_pkg::S_SH_RD: begin
        raddr      = IW'(idx_p1);
        state_next = uvst_pkg::S_SH_WR;
      end

      uvst_pkg::S_SH_WR: begin
        // move the next entry down over the gap
        mem_we = 1'b1;
        waddr  = idx;
        wdata  = rdata;
        if (idx_p2 < cnt_ext) begin
          idx_next   = idx + IW'(1);
          state_next = uvst_pkg::S_SH_RD;
        end else begin
          entry_count_next = entry_count - CW'(1);
          state_next       = uvst_pkg::S_DONE;
        end
      end

      uvst_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = uvst_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = uvst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ verif/unique_value_set_table_tb.sv @@
// Testbench for unique_value_set_table: random and directed set requests, with a
// built-in set predictor, in-order result checks, random input gaps and random output stalls.
// Depends on uvst_pkg and unique_value_set_table.
module unique_value_set_table_tb;

  localparam int unsigned CAPACITY = 16;
  localparam int POOL_SIZE = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic                          found;
    logic [uvst_pkg::POS_W-1:0]    position;
    logic [uvst_pkg::COUNT_W-1:0]  count;
    logic                          full_drop;
  } set_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    action = uvst_pkg::ACT_ADD;
  logic [uvst_pkg::KEY_W-1:0]    key = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          found;
  logic [uvst_pkg::POS_W-1:0]    position;
  logic [uvst_pkg::COUNT_W-1:0]  count;
  logic                          full_drop;

  // predictor state: packed set contents and occupancy
  logic [uvst_pkg::KEY_W-1:0]    held_keys [CAPACITY];
  int                            held_count = 0;
  set_result_t                   pending_results [$];
  logic [uvst_pkg::KEY_W-1:0]    key_pool [POOL_SIZE];

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;
  int  hold_gen = 0;
  int  hold_seen = 0;
  int  stall_left = 0;

  unique_value_set_table #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .position  (position),
    .count     (count),
    .full_drop (full_drop)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // apply one request to the predicted set and return the result it should produce
  function automatic set_result_t apply_request(logic [1:0] act,
                                                logic [uvst_pkg::KEY_W-1:0] k);
    set_result_t r;
    int hit;
    r = '0;
    hit = -1;
    if (act != uvst_pkg::ACT_CLEAR) begin
      for (int i = 0; i < held_count; i++) begin
        if (hit < 0 && held_keys[i] == k) hit = i;
      end
    end
    r.found = (hit >= 0);
    r.position = (hit >= 0) ? hit[uvst_pkg::POS_W-1:0] : '0;
    case (act)
      uvst_pkg::ACT_ADD: begin
        if (hit < 0) begin
          if (held_count < CAPACITY) begin
            held_keys[held_count] = k;
            held_count++;
          end else begin
            r.full_drop = 1'b1;
          end
        end
      end
      uvst_pkg::ACT_REMOVE: begin
        if (hit >= 0) begin
          // close the gap so the set stays packed from position zero
          for (int i = hit; i + 1 < held_count; i++) held_keys[i] = held_keys[i + 1];
          held_count--;
        end
      end
      uvst_pkg::ACT_CLEAR: held_count = 0;
      default: ;
    endcase
    r.count = held_count[uvst_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycles, msg);
    mismatches++;
  endtask

  // hold valid and payload until the block takes the request
  task automatic send_request(input logic [1:0] act, input logic [uvst_pkg::KEY_W-1:0] k);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    key <= k;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(act, k));
  endtask

  // result side: random stalls, plus a long hold-off whenever hold_gen advances
  always @(posedge clk) begin
    int g;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_seen != hold_gen) begin
      hold_seen = hold_gen;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      g = idle_on ? pick_gap() : 0;
      out_stall <= (g > 0);
      stall_left = (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk) begin
    set_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found)
          report_mismatch($sformatf("result %0d found got %b want %b",
                                    results_seen, found, want.found));
        if (position !== want.position)
          report_mismatch($sformatf("result %0d position got %0d want %0d",
                                    results_seen, position, want.position));
        if (count !== want.count)
          report_mismatch($sformatf("result %0d count got %0d want %0d",
                                    results_seen, count, want.count));
        if (full_drop !== want.full_drop)
          report_mismatch($sformatf("result %0d full_drop got %b want %b",
                                    results_seen, full_drop, want.full_drop));
      end
      results_seen++;
    end
  end

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 42) return uvst_pkg::ACT_ADD;
    if (r < 64) return uvst_pkg::ACT_REMOVE;
    if (r < 97) return uvst_pkg::ACT_LOOKUP;
    return uvst_pkg::ACT_CLEAR;
  endfunction

  // mostly keys from a small pool so hits, shifts and full drops are common
  function automatic logic [uvst_pkg::KEY_W-1:0] pick_key(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic fill_pool();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    // near neighbors: one bit apart, so the compare must see every bit
    key_pool[3] = key_pool[2] ^ (64'd1 << $urandom_range(0, uvst_pkg::KEY_W - 1));
    key_pool[5] = key_pool[4] ^ (64'd1 << (uvst_pkg::KEY_W - 1));
  endtask

  task automatic test_directed_edges();
    send_request(uvst_pkg::ACT_LOOKUP, '1);
    send_request(uvst_pkg::ACT_REMOVE, '0);
    send_request(uvst_pkg::ACT_ADD, '0);
    send_request(uvst_pkg::ACT_ADD, '1);
    send_request(uvst_pkg::ACT_ADD, '0);        // already held: found, no change
    send_request(uvst_pkg::ACT_REMOVE, '0);     // shifts the all-ones key down
    send_request(uvst_pkg::ACT_LOOKUP, '1);
    for (int i = 0; i < CAPACITY - 1; i++)
      send_request(uvst_pkg::ACT_ADD, 64'h8000_0000_0000_0000 >> i);
    send_request(uvst_pkg::ACT_ADD, 64'h5);     // set full: drop
    send_request(uvst_pkg::ACT_ADD, '1);        // held key on a full set: no drop
    send_request(uvst_pkg::ACT_CLEAR, '1);
  endtask

  task automatic test_random_churn(input int n, input int pool_pct);
    for (int i = 0; i < n; i++) send_request(pick_action(), pick_key(pool_pct));
  endtask

  task automatic test_steady_stream(input int n);
    idle_on = 1'b0;
    test_random_churn(n, 85);
    idle_on = 1'b1;
  endtask

  // hold the result side off while requests keep coming, so the block backs up
  task automatic test_output_hold_off(input int n);
    idle_on = 1'b0;
    hold_gen <= hold_gen + 1;
    test_random_churn(n, 85);
    idle_on = 1'b1;
  endtask

  initial begin
    fill_pool();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_random_churn(700, 85);
    test_steady_stream(250);
    test_output_hold_off(60);
    test_random_churn(400, 60);
    test_steady_stream(100);
    test_random_churn(200, 95);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
